@@ sv/longest_window_under_budget_assert.svh @@
// Assertion macros for the verification files of longest_window_under_budget.
// No dependencies; expects clk_i and rst_ni in the including scope.
`ifndef LONGEST_WINDOW_UNDER_BUDGET_ASSERT_SVH
`define LONGEST_WINDOW_UNDER_BUDGET_ASSERT_SVH

// checked while out of reset
`define LWUB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lwub assertion failed");

// checked at every edge, reset included
`define LWUB_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("lwub assertion failed");

`endif

@@ sv/lwub_pkg.sv @@
// Package for longest_window_under_budget: widths, defaults and the request type.
// No dependencies.
package lwub_pkg;

  localparam int unsigned DEPTH_DEF = 4096;
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned LEN_W     = 13;
  localparam int unsigned SUM_W     = 32;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ADDR_W    = 3;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
  } item_t;

endpackage

@@ sv/lwub_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module lwub_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

@@ sv/lwub_front.sv @@
// Front end of longest_window_under_budget: input queue of requests.
// Depends on lwub_pkg.
module lwub_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  lwub_pkg::item_t item_i,
  output logic            item_valid_o,
  output lwub_pkg::item_t item_o,
  input  logic            item_ready_i
);
  import lwub_pkg::*;

  localparam int unsigned QAW = $clog2(QDEPTH);
  localparam logic [QAW:0] QFULL = (QAW+1)'(QDEPTH);

  item_t          entries_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QAW:0]   cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full         = (cnt_q == QFULL);
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = entries_q[rd_ptr_q];
  assign do_push      = push && !full;
  assign do_pop       = item_valid_o && item_ready_i;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QAW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QAW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (QAW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ sv/lwub_back.sv @@
// Back end of longest_window_under_budget: sliding window sequencer and result slot.
// Depends on lwub_pkg and lwub_ram.
module lwub_back #(
  parameter int unsigned DEPTH = lwub_pkg::DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [lwub_pkg::SUM_W-1:0]   budget_i,
  input  logic                         item_valid_i,
  input  lwub_pkg::item_t              item_i,
  output logic                         item_ready_o,
  input  logic                         pop,
  output logic                         empty,
  output logic [lwub_pkg::LEN_W-1:0]   best_length_o
);
  import lwub_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DROP,
    S_PUSH,
    S_CHECK,
    S_POP
  } state_e;

  state_e             state_q, state_d;
  logic [AW-1:0]      head_q, head_d;
  logic [AW-1:0]      tail_q, tail_d;
  logic [CW-1:0]      count_q, count_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [CW-1:0]      best_q, best_d;
  item_t              item_q, item_d;
  logic               res_valid_q, res_valid_d;
  logic [LEN_W-1:0]   res_q, res_d;

  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [VALUE_W-1:0] ram_wdata;
  logic [VALUE_W-1:0] ram_rdata;
  logic [CW-1:0]      new_best;
  logic [CW+LEN_W-1:0] best_ext;

  function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + AW'(1);
  endfunction

  lwub_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign new_best = (count_q > best_q) ? count_q : best_q;
  assign best_ext = {LEN_W'(0), new_best};

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    sum_d        = sum_q;
    best_d       = best_q;
    item_d       = item_q;
    res_valid_d  = res_valid_q;
    res_d        = res_q;
    item_ready_o = 1'b0;
    ram_we       = 1'b0;
    ram_addr     = head_q;
    ram_wdata    = item_q.value;
    if (pop && res_valid_q) begin
      res_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          item_ready_o = 1'b1;
          item_d       = item_i;
          if (count_q == FULL_CNT) begin
            state_d = S_DROP;
          end else begin
            ram_we    = 1'b1;
            ram_addr  = tail_q;
            ram_wdata = item_i.value;
            tail_d    = next_idx(tail_q);
            count_d   = count_q + CW'(1);
            sum_d     = sum_q + SUM_W'(item_i.value);
            state_d   = S_CHECK;
          end
        end
      end
      S_DROP: begin
        sum_d   = sum_q - SUM_W'(ram_rdata);
        head_d  = next_idx(head_q);
        count_d = count_q - CW'(1);
        state_d = S_PUSH;
      end
      S_PUSH: begin
        ram_we   = 1'b1;
        ram_addr = tail_q;
        tail_d   = next_idx(tail_q);
        count_d  = count_q + CW'(1);
        sum_d    = sum_q + SUM_W'(item_q.value);
        state_d  = S_CHECK;
      end
      S_CHECK: begin
        if ((count_q != '0) && (sum_q > budget_i)) begin
          state_d = S_POP;
        end else if (!item_q.last) begin
          best_d  = new_best;
          state_d = S_IDLE;
        end else if (!res_valid_q || pop) begin
          res_valid_d = 1'b1;
          res_d       = best_ext[LEN_W-1:0];
          head_d      = '0;
          tail_d      = '0;
          count_d     = '0;
          sum_d       = '0;
          best_d      = '0;
          state_d     = S_IDLE;
        end
      end
      S_POP: begin
        sum_d   = sum_q - SUM_W'(ram_rdata);
        head_d  = next_idx(head_q);
        count_d = count_q - CW'(1);
        state_d = S_CHECK;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      best_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      best_q      <= best_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
  end

  assign empty         = !res_valid_q;
  assign best_length_o = res_q;

endmodule

@@ sv/longest_window_under_budget.sv @@
// longest_window_under_budget: for each set of 16-bit values (ended by last_i) it returns
// the longest run of consecutive values whose sum stays within the budget register,
// capped at DEPTH. Requests enter a 4-entry queue, so push is taken while the window
// engine works. Each value is written to the window and checked against the budget;
// while the sum exceeds the budget, entries are popped from the head of the window,
// and when the single-port window RAM already holds DEPTH entries the oldest is dropped first. The last
// value of a set adds a result to the output slot. Budget is written over APB at
// address 0 and must only change while the block is idle.
// Depends on lwub_pkg, lwub_front, lwub_back.
module longest_window_under_budget #(
  parameter int unsigned DEPTH = lwub_pkg::DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lwub_pkg::ADDR_W-1:0]   paddr,
  input  logic [lwub_pkg::DATA_W-1:0]   pwdata,
  output logic [lwub_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          push,
  output logic                          full,
  input  logic [lwub_pkg::VALUE_W-1:0]  value_i,
  input  logic                          last_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [lwub_pkg::LEN_W-1:0]    best_length_o
);
  import lwub_pkg::*;

  localparam logic REG_BUDGET = 1'b0;

  logic [SUM_W-1:0] budget_q;
  item_t            in_item;
  item_t            q_item;
  logic             q_valid;
  logic             q_ready;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BUDGET) ? DATA_W'(budget_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_BUDGET)) begin
      budget_q <= pwdata[SUM_W-1:0];
    end
  end

  assign in_item.value = value_i;
  assign in_item.last  = last_i;

  lwub_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .item_i       (in_item),
    .item_valid_o (q_valid),
    .item_o       (q_item),
    .item_ready_i (q_ready)
  );

  lwub_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .budget_i      (budget_q),
    .item_valid_i  (q_valid),
    .item_i        (q_item),
    .item_ready_o  (q_ready),
    .pop           (pop),
    .empty         (empty),
    .best_length_o (best_length_o)
  );

endmodule

@@ sv/lwub_checker.sv @@
// Port-level checks for longest_window_under_budget, bound to the top level.
// Depends on lwub_pkg and longest_window_under_budget_assert.svh.
`include "longest_window_under_budget_assert.svh"

module lwub_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [lwub_pkg::ADDR_W-1:0]   paddr,
  input logic [lwub_pkg::DATA_W-1:0]   pwdata,
  input logic [lwub_pkg::DATA_W-1:0]   prdata,
  input logic                          pready,
  input logic                          empty,
  input logic                          pop,
  input logic [lwub_pkg::LEN_W-1:0]    best_length_o
);

  // no result can be pending after a reset cycle
  `LWUB_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> empty)

  `LWUB_ASSERT_ALWAYS(a_pready_high, pready)

  // a stalled result holds
  `LWUB_ASSERT(a_result_hold, (!empty && !pop) |=> (!empty && $stable(best_length_o)))

  // budget reads back what was written
  `LWUB_ASSERT(a_budget_readback,
    (psel && penable && pwrite && !paddr[2]) |=> (paddr[2] || (prdata == $past(pwdata))))

endmodule

bind longest_window_under_budget lwub_checker u_lwub_checker (.*);
